// File: rtl/sgb_pkg.sv
// ----------------------------------------------------------------------------
// sgb_pkg
// Shared types, register indexes and helpers for the separable RGB blur.
// ----------------------------------------------------------------------------
package sgb_pkg;

    localparam int LINES     = 7;
    localparam int ACC_W     = 27;
    localparam int CFG_IDX_W = 3;
    localparam int CFG_DAT_W = 16;

    typedef enum logic [CFG_IDX_W-1:0] {
        REG_IMAGE_WIDTH   = 3'd0,
        REG_IMAGE_HEIGHT  = 3'd1,
        REG_KERNEL_RADIUS = 3'd2,
        REG_COEF_CENTER   = 3'd3,
        REG_COEF_DIST1    = 3'd4,
        REG_COEF_DIST2    = 3'd5,
        REG_COEF_DIST3    = 3'd6
    } sgb_reg_t;

    localparam logic [10:0] RST_IMAGE_WIDTH   = 11'd1024;
    localparam logic [10:0] RST_IMAGE_HEIGHT  = 11'd1024;
    localparam logic [1:0]  RST_KERNEL_RADIUS = 2'd1;
    localparam logic [15:0] RST_COEF_CENTER   = 16'd32768;
    localparam logic [15:0] RST_COEF_DIST1    = 16'd16384;
    localparam logic [15:0] RST_COEF_DIST2    = 16'd0;
    localparam logic [15:0] RST_COEF_DIST3    = 16'd0;

    localparam logic OP_PIXEL = 1'b0;
    localparam logic OP_DRAIN = 1'b1;

    typedef enum logic [3:0] {
        ST_IDLE,
        ST_LOOP,
        ST_ROW,
        ST_ROW_WR,
        ST_COL_RD,
        ST_COL_ACC,
        ST_EMIT,
        ST_NEXT,
        ST_FINISH
    } sgb_state_t;

    typedef struct packed {
        logic accept;
        logic loop_init;
        logic row_tap;
        logic row_store;
        logic col_read;
        logic col_tap;
        logic emit;
        logic next_x;
        logic finish;
    } sgb_cmd_t;

    typedef struct packed {
        logic in_img;
        logic loop_go;
        logic y_ok;
        logic tap_last;
        logic out_free;
    } sgb_status_t;

    // Drop the Q0.16 fraction and clamp to eight bits.
    function automatic logic [7:0] sat8(input logic [ACC_W-1:0] s);
        logic [ACC_W-17:0] q;
        begin
            q = s[ACC_W-1:16];
            sat8 = (q > (ACC_W-16)'(255)) ? 8'hFF : q[7:0];
        end
    endfunction

endpackage

// File: rtl/sgb_ctrl.sv
// ----------------------------------------------------------------------------
// sgb_ctrl
// Sequencer: walks each item through row taps, line write, column taps, emit.
// ----------------------------------------------------------------------------
module sgb_ctrl (
    input  logic                 clk,
    input  logic                 rst_n,
    input  logic                 s_tvalid,
    output logic                 s_tready,
    input  sgb_pkg::sgb_status_t status,
    output sgb_pkg::sgb_cmd_t    cmd
);
    import sgb_pkg::*;

    sgb_state_t state_reg;
    sgb_state_t state_next;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= ST_IDLE;
        end
        else
        begin
            state_reg <= state_next;
        end
    end

    always_comb
    begin
        state_next = state_reg;
        case (state_reg)
            ST_IDLE:
            begin
                if (s_tvalid)
                begin
                    state_next = ST_LOOP;
                end
            end
            ST_LOOP:
            begin
                if (!status.loop_go)
                begin
                    state_next = ST_FINISH;
                end
                else if (status.in_img)
                begin
                    state_next = ST_ROW;
                end
                else if (status.y_ok)
                begin
                    state_next = ST_COL_RD;
                end
                else
                begin
                    state_next = ST_NEXT;
                end
            end
            ST_ROW:
            begin
                if (status.tap_last)
                begin
                    state_next = ST_ROW_WR;
                end
            end
            ST_ROW_WR:  state_next = status.y_ok ? ST_COL_RD : ST_NEXT;
            ST_COL_RD:  state_next = ST_COL_ACC;
            ST_COL_ACC: state_next = status.tap_last ? ST_EMIT : ST_COL_RD;
            ST_EMIT:
            begin
                if (status.out_free)
                begin
                    state_next = ST_NEXT;
                end
            end
            ST_NEXT:    state_next = ST_LOOP;
            ST_FINISH:  state_next = ST_IDLE;
            default:    state_next = ST_IDLE;
        endcase
    end

    always_comb
    begin
        cmd      = '0;
        s_tready = 1'b0;
        case (state_reg)
            ST_IDLE:
            begin
                s_tready   = 1'b1;
                cmd.accept = s_tvalid;
            end
            ST_LOOP:    cmd.loop_init = 1'b1;
            ST_ROW:     cmd.row_tap   = 1'b1;
            ST_ROW_WR:  cmd.row_store = 1'b1;
            ST_COL_RD:  cmd.col_read  = 1'b1;
            ST_COL_ACC: cmd.col_tap   = 1'b1;
            ST_EMIT:    cmd.emit      = status.out_free;
            ST_NEXT:    cmd.next_x    = 1'b1;
            ST_FINISH:  cmd.finish    = 1'b1;
            default:    cmd           = '0;
        endcase
    end

endmodule

// File: rtl/sgb_datapath.sv
// ----------------------------------------------------------------------------
// sgb_datapath
// Registers, row window, seven-line buffer, shared MAC and output register.
// ----------------------------------------------------------------------------
module sgb_datapath #(
    parameter int MAX_WIDTH  = 1024,
    parameter int MAX_HEIGHT = 1024
) (
    input  logic                 clk,
    input  logic                 rst_n,
    input  logic                 cfg_valid,
    input  logic [2:0]           cfg_index,
    input  logic [15:0]          cfg_data,
    input  logic                 in_opcode,
    input  logic [23:0]          in_rgb,
    output logic                 m_tvalid,
    input  logic                 m_tready,
    output logic [47:0]          m_tdata,
    output logic                 m_tlast,
    input  sgb_pkg::sgb_cmd_t    cmd,
    output sgb_pkg::sgb_status_t status
);
    import sgb_pkg::*;

    localparam int XW    = $clog2(MAX_WIDTH);
    localparam int CW    = $clog2(MAX_WIDTH + 1);
    localparam int RW    = $clog2(MAX_HEIGHT + 4);
    localparam int DEPTH = LINES * MAX_WIDTH;
    localparam int AW    = $clog2(DEPTH);

    logic [10:0] image_width_reg;
    logic [10:0] image_height_reg;
    logic [1:0]  kernel_radius_reg;
    logic [15:0] coef_center_reg;
    logic [15:0] coef_dist1_reg;
    logic [15:0] coef_dist2_reg;
    logic [15:0] coef_dist3_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            image_width_reg   <= RST_IMAGE_WIDTH;
            image_height_reg  <= RST_IMAGE_HEIGHT;
            kernel_radius_reg <= RST_KERNEL_RADIUS;
            coef_center_reg   <= RST_COEF_CENTER;
            coef_dist1_reg    <= RST_COEF_DIST1;
            coef_dist2_reg    <= RST_COEF_DIST2;
            coef_dist3_reg    <= RST_COEF_DIST3;
        end
        else if (cfg_valid)
        begin
            case (sgb_reg_t'(cfg_index))
                REG_IMAGE_WIDTH:   image_width_reg   <= cfg_data[10:0];
                REG_IMAGE_HEIGHT:  image_height_reg  <= cfg_data[10:0];
                REG_KERNEL_RADIUS: kernel_radius_reg <= cfg_data[1:0];
                REG_COEF_CENTER:   coef_center_reg   <= cfg_data;
                REG_COEF_DIST1:    coef_dist1_reg    <= cfg_data;
                REG_COEF_DIST2:    coef_dist2_reg    <= cfg_data;
                REG_COEF_DIST3:    coef_dist3_reg    <= cfg_data;
                default:           ;
            endcase
        end
    end

    // Effective geometry: zero acts as one, oversized values clamp.
    logic [CW-1:0] eff_w;
    logic [RW-1:0] eff_h;
    logic [RW-1:0] frame_rows;

    always_comb
    begin
        if (image_width_reg == 11'd0)
            eff_w = CW'(1);
        else if (32'(image_width_reg) > 32'(MAX_WIDTH))
            eff_w = CW'(MAX_WIDTH);
        else
            eff_w = CW'(image_width_reg);
        if (image_height_reg == 11'd0)
            eff_h = RW'(1);
        else if (32'(image_height_reg) > 32'(MAX_HEIGHT))
            eff_h = RW'(MAX_HEIGHT);
        else
            eff_h = RW'(image_height_reg);
        frame_rows = eff_h + RW'(kernel_radius_reg);
    end

    logic [CW-1:0] col_cnt_reg;
    logic [RW-1:0] row_cnt_reg;
    logic [2:0]    line_reg;
    logic [CW-1:0] x_reg;
    logic [2:0]    tap_reg;
    logic [23:0]   win_reg [LINES];
    logic [ACC_W-1:0] acc_r_reg, acc_g_reg, acc_b_reg;
    logic [23:0]   row_val_reg;
    logic [23:0]   mem_q_reg;
    logic [23:0]   line_mem [DEPTH];

    logic [1:0] r;
    logic [2:0] two_r;
    assign r     = kernel_radius_reg;
    assign two_r = {kernel_radius_reg, 1'b0};

    // Position of the item being accepted, after any frame restart.
    logic          restart;
    logic [CW-1:0] acc_c;
    logic [RW-1:0] acc_row;
    logic          acc_in_img;
    assign restart    = (col_cnt_reg >= eff_w) || (row_cnt_reg >= frame_rows);
    assign acc_c      = restart ? '0 : col_cnt_reg;
    assign acc_row    = restart ? '0 : row_cnt_reg;
    assign acc_in_img = acc_row < eff_h;

    logic last_col;
    logic in_img;
    logic y_ok;
    logic [RW-1:0] y_val;
    assign last_col = col_cnt_reg == (eff_w - CW'(1));
    assign in_img   = row_cnt_reg < eff_h;
    assign y_val    = row_cnt_reg - RW'(r);
    assign y_ok     = (row_cnt_reg >= RW'(r)) && (y_val < eff_h);

    // Tap distance from the centre.
    logic [1:0] tap_dist;
    logic [15:0] coef;
    assign tap_dist = (tap_reg >= 3'(r)) ? 2'(tap_reg - 3'(r)) : 2'(3'(r) - tap_reg);
    always_comb
    begin
        case (tap_dist)
            2'd0:    coef = coef_center_reg;
            2'd1:    coef = coef_dist1_reg;
            2'd2:    coef = coef_dist2_reg;
            default: coef = coef_dist3_reg;
        endcase
    end

    // Row tap: column x + tap - r, kept only inside 0..C.
    logic [CW:0] row_sum;
    logic [CW:0] row_col;
    logic        row_ok;
    logic [2:0]  win_k;
    logic [23:0] row_px;
    assign row_sum = (CW+1)'(x_reg) + (CW+1)'(tap_reg);
    assign row_col = row_sum - (CW+1)'(r);
    assign row_ok  = (row_sum >= (CW+1)'(r)) && (row_col <= (CW+1)'(col_cnt_reg));
    assign win_k   = 3'((CW+1)'(col_cnt_reg) - row_col);
    assign row_px  = (row_ok && (win_k < 3'(LINES))) ? win_reg[win_k] : 24'd0;

    // Column tap: row R + tap - 2r, kept only inside the image.
    logic [RW:0] col_sum;
    logic        col_ok;
    logic        bypass;
    logic [2:0]  back;
    logic [2:0]  rd_line;
    logic [23:0] col_px;
    assign col_sum = (RW+1)'(row_cnt_reg) + (RW+1)'(tap_reg);
    assign col_ok  = (col_sum >= (RW+1)'(two_r))
                     && ((col_sum - (RW+1)'(two_r)) < (RW+1)'(eff_h));
    assign bypass  = tap_reg == two_r;
    assign back    = two_r - tap_reg;
    assign rd_line = (line_reg >= back) ? (line_reg - back) : (line_reg + 3'(LINES) - back);
    assign col_px  = !col_ok ? 24'd0 : (bypass ? row_val_reg : mem_q_reg);

    logic [AW-1:0] wr_addr;
    logic [AW-1:0] rd_addr;
    assign wr_addr = AW'(line_reg) * AW'(MAX_WIDTH) + AW'(x_reg[XW-1:0]);
    assign rd_addr = AW'(rd_line) * AW'(MAX_WIDTH) + AW'(x_reg[XW-1:0]);

    logic [23:0] mac_px;
    logic [ACC_W-1:0] prod_r, prod_g, prod_b;
    assign mac_px = cmd.row_tap ? row_px : col_px;
    assign prod_r = ACC_W'(mac_px[23:16]) * ACC_W'(coef);
    assign prod_g = ACC_W'(mac_px[15:8]) * ACC_W'(coef);
    assign prod_b = ACC_W'(mac_px[7:0]) * ACC_W'(coef);

    logic [23:0] sat_px;
    assign sat_px = {sat8(acc_r_reg), sat8(acc_g_reg), sat8(acc_b_reg)};

    always_ff @(posedge clk)
    begin
        if (cmd.row_store)
        begin
            line_mem[wr_addr] <= sat_px;
        end
        if (cmd.col_read)
        begin
            mem_q_reg <= line_mem[rd_addr];
        end
    end

    always_ff @(posedge clk)
    begin
        if (cmd.row_store)
        begin
            row_val_reg <= sat_px;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            col_cnt_reg <= '0;
            row_cnt_reg <= '0;
            line_reg    <= '0;
            x_reg       <= '0;
            tap_reg     <= '0;
            acc_r_reg   <= '0;
            acc_g_reg   <= '0;
            acc_b_reg   <= '0;
            for (int i = 0; i < LINES; i++)
            begin
                win_reg[i] <= '0;
            end
        end
        else
        begin
            if (cmd.accept)
            begin
                col_cnt_reg <= acc_c;
                row_cnt_reg <= acc_row;
                if (restart)
                begin
                    line_reg <= '0;
                end
                x_reg <= (acc_c >= CW'(r)) ? (acc_c - CW'(r)) : '0;
                if (acc_in_img)
                begin
                    for (int i = LINES - 1; i > 0; i--)
                    begin
                        win_reg[i] <= win_reg[i-1];
                    end
                    win_reg[0] <= (in_opcode == OP_PIXEL) ? in_rgb : 24'd0;
                end
            end
            if (cmd.loop_init || cmd.row_store)
            begin
                tap_reg   <= '0;
                acc_r_reg <= '0;
                acc_g_reg <= '0;
                acc_b_reg <= '0;
            end
            if (cmd.row_tap || cmd.col_tap)
            begin
                tap_reg   <= tap_reg + 3'd1;
                acc_r_reg <= acc_r_reg + prod_r;
                acc_g_reg <= acc_g_reg + prod_g;
                acc_b_reg <= acc_b_reg + prod_b;
            end
            if (cmd.next_x)
            begin
                x_reg <= x_reg + CW'(1);
            end
            if (cmd.finish)
            begin
                if (last_col)
                begin
                    col_cnt_reg <= '0;
                    if ((row_cnt_reg + RW'(1)) >= frame_rows)
                    begin
                        row_cnt_reg <= '0;
                        line_reg    <= '0;
                    end
                    else
                    begin
                        row_cnt_reg <= row_cnt_reg + RW'(1);
                        line_reg    <= (line_reg == 3'(LINES - 1)) ? 3'd0 : line_reg + 3'd1;
                    end
                end
                else
                begin
                    col_cnt_reg <= col_cnt_reg + CW'(1);
                end
            end
        end
    end

    // The x loop runs to C on the last column, else to C - r.
    logic loop_go;
    assign loop_go = last_col ? (x_reg <= col_cnt_reg)
                              : ((CW+1)'(x_reg) + (CW+1)'(r) <= (CW+1)'(col_cnt_reg));

    logic x_last;
    assign x_last = last_col ? (x_reg == col_cnt_reg)
                             : ((CW+1)'(x_reg) + (CW+1)'(r) == (CW+1)'(col_cnt_reg));

    logic        out_valid_reg;
    logic [47:0] out_data_reg;
    logic        out_last_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_valid_reg <= 1'b0;
        end
        else if (cmd.emit)
        begin
            out_valid_reg <= 1'b1;
        end
        else if (m_tready)
        begin
            out_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge clk)
    begin
        if (cmd.emit)
        begin
            out_data_reg <= {4'd0, 10'(y_val), 10'(x_reg), sat_px[7:0], sat_px[15:8],
                             sat_px[23:16]};
            out_last_reg <= x_last;
        end
    end

    assign m_tvalid = out_valid_reg;
    assign m_tdata  = out_data_reg;
    assign m_tlast  = out_last_reg;

    assign status.in_img   = in_img;
    assign status.loop_go  = loop_go;
    assign status.y_ok     = y_ok;
    assign status.tap_last = tap_reg == two_r;
    assign status.out_free = !out_valid_reg || m_tready;

endmodule

// File: rtl/separable_gaussian_blur_rgb.sv
// Sequence: each item is accepted, then for each output column it finishes the
// x loop steps through row taps and line write (rows inside the image) and
// column taps and emit (when an output row is due); the emit may wait on
// m_tready. A new item is accepted only once the last one is through, as the
// work is done by the single shared MAC and the one read port of the line
// buffer. Reset clears control and registers.
// ----------------------------------------------------------------------------
// separable_gaussian_blur_rgb
// Row-then-column Gaussian blur of an RGB raster stream with darkened edges.
// ----------------------------------------------------------------------------
module separable_gaussian_blur_rgb #(
    parameter int MAX_WIDTH  = 1024,
    parameter int MAX_HEIGHT = 1024
) (
    input  logic        clk,
    input  logic        rst_n,
    input  logic        s_tvalid,
    output logic        s_tready,
    input  logic [23:0] s_tdata,   // red, green, blue
    input  logic        s_tuser,   // opcode
    output logic        m_tvalid,
    input  logic        m_tready,
    output logic [47:0] m_tdata,   // blurred_red, blurred_green, blurred_blue,
                                   // out_column, out_row, zero pad
    output logic        m_tlast,
    input  logic        cfg_valid,
    output logic        cfg_ready,
    input  logic [2:0]  cfg_index,
    input  logic [15:0] cfg_data
);
    import sgb_pkg::*;

    sgb_cmd_t    cmd;
    sgb_status_t status;

    assign cfg_ready = 1'b1;

    sgb_ctrl u_ctrl (
        .clk      (clk),
        .rst_n    (rst_n),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .status   (status),
        .cmd      (cmd)
    );

    sgb_datapath #(
        .MAX_WIDTH  (MAX_WIDTH),
        .MAX_HEIGHT (MAX_HEIGHT)
    ) u_datapath (
        .clk       (clk),
        .rst_n     (rst_n),
        .cfg_valid (cfg_valid),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data),
        .in_opcode (s_tuser),
        .in_rgb    ({s_tdata[7:0], s_tdata[15:8], s_tdata[23:16]}),
        .m_tvalid  (m_tvalid),
        .m_tready  (m_tready),
        .m_tdata   (m_tdata),
        .m_tlast   (m_tlast),
        .cmd       (cmd),
        .status    (status)
    );

endmodule
